/* src/mfd_pkg.sv */
// Shared types and constants for the media frame deframer.
`timescale 1ns / 1ps

package mfd_pkg;

   // parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_STATS   = 2'd2;
   localparam logic [1:0] PH_HALTED  = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_STOP      = 3'd1;
   localparam logic [2:0] KIND_MAGIC     = 3'd2;
   localparam logic [2:0] KIND_TOO_LARGE = 3'd3;
   localparam logic [2:0] KIND_PING      = 3'd4;

   localparam logic [7:0] MAGIC_FIRST  = 8'h51;
   localparam logic [7:0] MAGIC_SECOND = 8'h43;
   localparam logic [7:0] STOP_FLAGS   = 8'h82;

   // bit positions inside the flags byte
   localparam int KEY_BIT    = 0;
   localparam int CONFIG_BIT = 1;
   localparam int HEVC_BIT   = 2;
   localparam int AUDIO_BIT  = 3;
   localparam int PING_BIT   = 6;

   // header byte offsets
   localparam int POS_MAGIC0     = 0;
   localparam int POS_MAGIC1     = 1;
   localparam int POS_FLAGS      = 3;
   localparam int POS_STAMP_LO   = 8;
   localparam int POS_STAMP_HI   = 15;
   localparam int POS_SIZE_LO    = 16;
   localparam int POS_SIZE_HI    = 19;
   localparam int HEADER_BYTES   = 20;
   localparam int STATS_BYTES    = 8;

   localparam int LIMIT_WIDTH    = 26;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 26'd33554432;

   // result fields that do not depend on the length width
   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         data_out;
      logic               is_audio;
      logic               keyframe;
      logic               codec_config;
      logic               hevc_coded;
      logic signed [63:0] timestamp_ms;
      logic               last_byte;
   } rsp_type;

endpackage

/* src/media_frame_deframer.sv */
// Media frame deframer: byte-serial header parser and payload emitter.
//
// Usage:
//   req_* channel: one stream byte per transaction (req_data_byte) with
//   req_connection_start marking the first byte of a new connection, which
//   clears the parser before that byte is taken as header byte 0.
//   rsp_* channel: at most one result per input byte; payload bytes carry
//   the frame flags, timestamp and length, and last_byte on the final one.
//   Status results (stop, bad magic, too large, ping stats) carry only kind.
//   csr_* channel: writes max_payload_bytes; always ready. Write it only
//   while the block is idle.
// Timing: one byte accepted per cycle while req_stall is low; each result is
//   registered in the output register or skid entry. The whole per-byte update
//   is one level of logic from the parser state registers to the result register.
// Reset: clears the parser to header phase and the size limit to 2^25.
// Stall: an output register plus one skid entry; req_stall rises only when
//   the skid entry is full.
`timescale 1ns / 1ps

module media_frame_deframer #(
   parameter int LENGTH_WIDTH = 26
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_connection_start,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_data_out,
   output logic                    rsp_is_audio,
   output logic                    rsp_keyframe,
   output logic                    rsp_codec_config,
   output logic                    rsp_hevc_coded,
   output logic signed [63:0]      rsp_timestamp_ms,
   output logic [LENGTH_WIDTH-1:0] rsp_frame_length,
   output logic                    rsp_last_byte,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [mfd_pkg::LIMIT_WIDTH-1:0] csr_max_payload_bytes
);

   localparam int LW = LENGTH_WIDTH;
   localparam logic [32:0] SIZE_CAP = 33'd1 << (LW - 1);

   // configuration
   logic [mfd_pkg::LIMIT_WIDTH-1:0] limit_ff;

   // parser state
   logic [1:0]    phase_ff, phase_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          magic_ok_ff, magic_ok_in;
   logic [7:0]    flag_ff, flag_in;
   logic [63:0]   stamp_ff, stamp_in;
   logic [31:0]   size_ff, size_in;
   logic [LW-1:0] len_ff, len_in;

   // output register and skid entry
   logic                 out_valid_ff;
   mfd_pkg::rsp_type     out_ff;
   logic [LW-1:0]        out_len_ff;
   logic                 skid_valid_ff;
   mfd_pkg::rsp_type     skid_ff;
   logic [LW-1:0]        skid_len_ff;

   logic                 req_accept;
   logic                 res_valid;
   mfd_pkg::rsp_type     res;
   logic [LW-1:0]        res_len;

   logic [1:0]    cur_phase;
   logic [LW-1:0] cur_pos;
   logic          cur_magic_ok;
   logic [LW-1:0] pos_inc;
   logic [31:0]   size_shift;
   logic [32:0]   limit_eff;
   logic          magic_ok_hdr;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mfd_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_max_payload_bytes;
      end
   end

   // limit above SIZE_CAP, 2^(LW-1), acts as the cap
   assign limit_eff = ({7'd0, limit_ff} > SIZE_CAP) ? SIZE_CAP : {7'd0, limit_ff};

   always_comb begin
      // connection start clears the parser ahead of this byte
      cur_phase    = req_connection_start ? mfd_pkg::PH_HEADER : phase_ff;
      cur_pos      = req_connection_start ? '0 : pos_ff;
      cur_magic_ok = req_connection_start ? 1'b1 : magic_ok_ff;
      pos_inc      = cur_pos + LW'(1);
      size_shift   = {size_ff[23:0], req_data_byte};

      phase_in    = cur_phase;
      pos_in      = cur_pos;
      magic_ok_in = cur_magic_ok;
      flag_in     = flag_ff;
      stamp_in    = stamp_ff;
      size_in     = size_ff;
      len_in      = len_ff;
      magic_ok_hdr = cur_magic_ok;

      res_valid = 1'b0;
      res       = '0;
      res_len   = '0;

      unique case (cur_phase)
         mfd_pkg::PH_HEADER: begin
            if ((cur_pos == LW'(mfd_pkg::POS_MAGIC0) &&
                 req_data_byte != mfd_pkg::MAGIC_FIRST) ||
                (cur_pos == LW'(mfd_pkg::POS_MAGIC1) &&
                 req_data_byte != mfd_pkg::MAGIC_SECOND)) begin
               magic_ok_hdr = 1'b0;
            end
            magic_ok_in = magic_ok_hdr;
            if (cur_pos == LW'(mfd_pkg::POS_FLAGS)) begin
               flag_in = req_data_byte;
            end
            if (cur_pos >= LW'(mfd_pkg::POS_STAMP_LO) &&
                cur_pos <= LW'(mfd_pkg::POS_STAMP_HI)) begin
               stamp_in = {stamp_ff[55:0], req_data_byte};
            end
            if (cur_pos >= LW'(mfd_pkg::POS_SIZE_LO) &&
                cur_pos <= LW'(mfd_pkg::POS_SIZE_HI)) begin
               size_in = size_shift;
            end
            pos_in = pos_inc;
            if (cur_pos == LW'(mfd_pkg::POS_SIZE_HI)) begin
               // header complete: checks in priority order
               pos_in = '0;
               len_in = size_shift[LW-1:0];
               if (!magic_ok_hdr) begin
                  phase_in  = mfd_pkg::PH_HALTED;
                  res_valid = 1'b1;
                  res.kind  = mfd_pkg::KIND_MAGIC;
               end else if (flag_ff == mfd_pkg::STOP_FLAGS) begin
                  phase_in  = mfd_pkg::PH_HALTED;
                  res_valid = 1'b1;
                  res.kind  = mfd_pkg::KIND_STOP;
               end else if ({1'b0, size_shift} > limit_eff) begin
                  phase_in  = mfd_pkg::PH_HALTED;
                  res_valid = 1'b1;
                  res.kind  = mfd_pkg::KIND_TOO_LARGE;
               end else if (flag_ff[mfd_pkg::PING_BIT]) begin
                  phase_in = mfd_pkg::PH_STATS;
               end else if (size_shift == 32'd0) begin
                  magic_ok_in = 1'b1;
               end else begin
                  phase_in = mfd_pkg::PH_PAYLOAD;
               end
            end
         end
         mfd_pkg::PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.kind         = mfd_pkg::KIND_PAYLOAD;
            res.data_out     = req_data_byte;
            res.is_audio     = flag_ff[mfd_pkg::AUDIO_BIT];
            res.keyframe     = flag_ff[mfd_pkg::KEY_BIT];
            res.codec_config = flag_ff[mfd_pkg::CONFIG_BIT];
            res.hevc_coded   = flag_ff[mfd_pkg::HEVC_BIT];
            res.timestamp_ms = stamp_ff;
            res_len          = len_ff;
            pos_in           = pos_inc;
            if (pos_inc == len_ff) begin
               res.last_byte = 1'b1;
               phase_in      = mfd_pkg::PH_HEADER;
               pos_in        = '0;
               magic_ok_in   = 1'b1;
            end
         end
         mfd_pkg::PH_STATS: begin
            pos_in = pos_inc;
            if (pos_inc == LW'(mfd_pkg::STATS_BYTES)) begin
               res_valid   = 1'b1;
               res.kind    = mfd_pkg::KIND_PING;
               phase_in    = mfd_pkg::PH_HEADER;
               pos_in      = '0;
               magic_ok_in = 1'b1;
            end
         end
         mfd_pkg::PH_HALTED: begin
            pos_in = cur_pos;
         end
         default: begin
            phase_in = mfd_pkg::PH_HALTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mfd_pkg::PH_HEADER;
         pos_ff      <= '0;
         magic_ok_ff <= 1'b1;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         magic_ok_ff <= magic_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         flag_ff  <= flag_in;
         stamp_ff <= stamp_in;
         size_ff  <= size_in;
         len_ff   <= len_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (!rsp_stall) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (out_valid_ff && rsp_stall) begin
            skid_valid_ff <= req_accept && res_valid;
         end else begin
            out_valid_ff <= req_accept && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff     <= skid_ff;
            out_len_ff <= skid_len_ff;
         end
      end else if (out_valid_ff && rsp_stall) begin
         skid_ff     <= res;
         skid_len_ff <= res_len;
      end else begin
         out_ff     <= res;
         out_len_ff <= res_len;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data_out     = out_ff.data_out;
   assign rsp_is_audio     = out_ff.is_audio;
   assign rsp_keyframe     = out_ff.keyframe;
   assign rsp_codec_config = out_ff.codec_config;
   assign rsp_hevc_coded   = out_ff.hevc_coded;
   assign rsp_timestamp_ms = out_ff.timestamp_ms;
   assign rsp_frame_length = out_len_ff;
   assign rsp_last_byte    = out_ff.last_byte;

   // skid entry only fills behind a valid output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output valid");

   // a waiting skid entry holds while the receiver stalls
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost or changed under stall");

   // last_byte only on payload results
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.last_byte |-> out_ff.kind == mfd_pkg::KIND_PAYLOAD)
      else $error("last_byte on a status result");

   // halted stays halted until a new connection
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mfd_pkg::PH_HALTED && !(req_accept && req_connection_start)
      |=> phase_ff == mfd_pkg::PH_HALTED)
      else $error("left halted phase without connection start");

   // a result is produced in halted phase never
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == mfd_pkg::PH_HALTED && !req_connection_start
      |-> !res_valid)
      else $error("result produced while halted");

endmodule
